>>> rtl/prq_pkg.sv
// Shared types and constants for the priority ready queue scheduler.
// No dependencies; every other file refers to it by scoped names.
package prq_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int NUM_LEVELS = 16;

    localparam int TASK_W  = $clog2(NUM_TASKS);
    localparam int LEVEL_W = $clog2(NUM_LEVELS);

    localparam int OPCODE_W  = 2;
    localparam int FIELD_W   = 8;
    localparam int CHOSEN_W  = 4;
    localparam int S_TDATA_W = 2 * FIELD_W;
    localparam int M_TDATA_W = 8;

    localparam logic [OPCODE_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FIELD_W-1:0]  task_number;
        logic [FIELD_W-1:0]  level;
    } t_req;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen_task;
        logic                found;
        logic                error;
    } t_rsp;

endpackage

>>> rtl/prq_queue_state.sv
// Linked-list ready queues: per-level head, tail and non-empty flag, per-task link
// and queued flag. Depends on prq_pkg.
module prq_queue_state (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  prq_pkg::t_req i_req,
    output prq_pkg::t_rsp o_rsp
);

    logic [prq_pkg::TASK_W-1:0]  r_next  [prq_pkg::NUM_TASKS];
    logic [prq_pkg::TASK_W-1:0]  r_head  [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::TASK_W-1:0]  r_tail  [prq_pkg::NUM_LEVELS];
    logic [prq_pkg::NUM_TASKS-1:0]  r_queued;
    logic [prq_pkg::NUM_LEVELS-1:0] r_nonempty;

    logic                         is_enq;
    logic                         is_deq;
    logic                         is_peek;
    logic                         id_ok;
    logic                         lv_ok;
    logic                         enq_ok;
    logic [prq_pkg::TASK_W-1:0]   id_idx;
    logic [prq_pkg::LEVEL_W-1:0]  lv_idx;
    logic [prq_pkg::LEVEL_W-1:0]  top_lvl;
    logic                         any_ready;
    logic [prq_pkg::LEVEL_W-1:0]  tail_addr;
    logic [prq_pkg::TASK_W-1:0]   tail_q;
    logic [prq_pkg::TASK_W-1:0]   head_id;
    logic [prq_pkg::TASK_W-1:0]   link_id;
    logic [prq_pkg::FIELD_W-1:0]  head_wide;
    logic                         deq_hit;

    assign is_enq  = (i_req.opcode == prq_pkg::OP_ENQ);
    assign is_deq  = (i_req.opcode == prq_pkg::OP_DEQ);
    assign is_peek = (i_req.opcode == prq_pkg::OP_PEEK);

    assign id_ok  = (i_req.task_number < prq_pkg::FIELD_W'(prq_pkg::NUM_TASKS));
    assign lv_ok  = (i_req.level < prq_pkg::FIELD_W'(prq_pkg::NUM_LEVELS));
    assign id_idx = i_req.task_number[prq_pkg::TASK_W-1:0];
    assign lv_idx = i_req.level[prq_pkg::LEVEL_W-1:0];
    assign enq_ok = is_enq && id_ok && lv_ok && !r_queued[id_idx];

    // Priority encoder: lowest-numbered non-empty level wins.
    always_comb begin
        top_lvl = '0;
        for (int l = prq_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_nonempty[l]) begin
                top_lvl = prq_pkg::LEVEL_W'(l);
            end
        end
    end
    assign any_ready = |r_nonempty;

    // One tail read port, shared between the enqueue and dequeue cases.
    assign tail_addr = is_enq ? lv_idx : top_lvl;
    assign tail_q    = r_tail[tail_addr];
    assign head_id   = r_head[top_lvl];
    assign link_id   = r_next[head_id];
    assign head_wide = prq_pkg::FIELD_W'(head_id);
    assign deq_hit   = is_deq && any_ready;

    always_comb begin
        o_rsp = '0;
        if (is_enq) begin
            o_rsp.error = !enq_ok;
        end else if ((is_deq || is_peek) && any_ready) begin
            o_rsp.found       = 1'b1;
            o_rsp.chosen_task = head_wide[prq_pkg::CHOSEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued   <= '0;
            r_nonempty <= '0;
        end else if (i_fire) begin
            if (enq_ok) begin
                r_queued[id_idx]   <= 1'b1;
                r_nonempty[lv_idx] <= 1'b1;
            end else if (deq_hit) begin
                r_queued[head_id] <= 1'b0;
                if (head_id == tail_q) begin
                    r_nonempty[top_lvl] <= 1'b0;
                end
            end
        end
    end

    // Links, heads and tails are only read while a live queue holds them.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (enq_ok) begin
                if (r_nonempty[lv_idx]) begin
                    r_next[tail_q] <= id_idx;
                end else begin
                    r_head[lv_idx] <= id_idx;
                end
                r_tail[lv_idx] <= id_idx;
            end else if (deq_hit && (head_id != tail_q)) begin
                r_head[top_lvl] <= link_id;
            end
        end
    end

endmodule

>>> rtl/priority_ready_queue_scheduler_unit.sv
// Top level of the multilevel priority ready queue scheduler.
// Depends on prq_pkg and prq_queue_state.
//
//  channel  | direction | tdata (low bit up)                | tuser
//  ---------+-----------+-----------------------------------+-------------
//  s (cmd)  | in        | task_number[7:0], level[15:8]     | opcode[1:0]
//  m (rsp)  | out       | chosen_task[3:0], found[4],       | none
//           |           | error[5], zero[7:6]               |
//
// Every command produces exactly one response beat, which passes through the
// input register and then the output register. A new command can be accepted
// every cycle while the output is not stalled; the queue state is updated as a
// command moves between the two registers, so the next command always sees it.
// Reset is synchronous and active low; it empties every level and clears both
// pipeline valid flags. A stall on the response side backs up into s_tready.
module priority_ready_queue_scheduler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [prq_pkg::S_TDATA_W-1:0] i_s_tdata,  // task_number, level
    input  logic [prq_pkg::OPCODE_W-1:0]  i_s_tuser,  // opcode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [prq_pkg::M_TDATA_W-1:0] o_m_tdata   // chosen_task, found, error
);

    prq_pkg::t_req r_in;
    logic          r_in_valid;
    prq_pkg::t_rsp r_out;
    logic          r_out_valid;
    prq_pkg::t_rsp rsp;
    logic          advance;
    logic          fire;
    logic          s_accept;

    // The output register can take a new response when empty or draining.
    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.opcode      <= i_s_tuser;
            r_in.task_number <= i_s_tdata[prq_pkg::FIELD_W-1:0];
            r_in.level       <= i_s_tdata[prq_pkg::S_TDATA_W-1:prq_pkg::FIELD_W];
        end
    end

    prq_queue_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= rsp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.error, r_out.found, r_out.chosen_task};

endmodule

>>> rtl/prq_checker.sv
// Port-level checks for the priority ready queue scheduler, bound to the top level.
// Depends on priority_ready_queue_scheduler_unit and prq_pkg.
module prq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [prq_pkg::M_TDATA_W-1:0] o_m_tdata
);

    // A response is never both a found task and a refused enqueue.
    a_found_error_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[4] && o_m_tdata[5]))
        else $error("response marks both found and error");

    // Without a found task the id field reads zero.
    a_idle_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[4]) |-> (o_m_tdata[3:0] == '0))
        else $error("id nonzero on a response without a task");

    // Nothing is shown in the first cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("response valid right after reset");

    // A stalled response keeps its valid and its data.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("response dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("response data changed while stalled");

endmodule

bind priority_ready_queue_scheduler_unit prq_checker u_prq_checker (.*);
